[rtl/tsfm_pkg.sv]
// Shared constants for the touch sample filter and coordinate mapper.
`default_nettype none

package tsfm_pkg;

	localparam int SAMPLE_W   = 12;
	localparam int ADDR_W     = 5;
	localparam int REG_IDX_W  = ADDR_W - 2;
	localparam int DIV_BITS   = 4;

	localparam logic [REG_IDX_W-1:0] REG_X_OFFSET  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_X_SPAN    = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_Y_OFFSET  = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_Y_SPAN    = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_SWAP_AXES = 3'd4;
	localparam logic [REG_IDX_W-1:0] REG_MIRROR_X  = 3'd5;
	localparam logic [REG_IDX_W-1:0] REG_MIRROR_Y  = 3'd6;

	localparam logic [SAMPLE_W-1:0] OFFSET_RST = 12'd300;
	localparam logic [SAMPLE_W-1:0] SPAN_RST   = 12'd3600;

endpackage

`default_nettype wire

[rtl/touch_sample_filter_and_map_core.sv]
// Touch sample filter and coordinate mapper: closest-pair filter, swap, offset, scale, divide, mirror.
// Pipeline: filter stage, swap and offset stage, scale stage, NSTG divider stages and the output
// register, where NSTG is the number of divider stages (quotient bits / 4, rounded up).
// Throughput: one request per cycle; busy stays low, the divider is fully pipelined
// at four quotient bits per stage. The receiver cannot stall, so nothing backs up.
// Reset: arst_n clears all valid bits and loads the calibration registers to defaults.
`default_nettype none

module touch_sample_filter_and_map_core #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	output logic                        busy,
	input  logic [11:0]                 x_sample_a,
	input  logic [11:0]                 x_sample_b,
	input  logic [11:0]                 x_sample_c,
	input  logic [11:0]                 y_sample_a,
	input  logic [11:0]                 y_sample_b,
	input  logic [11:0]                 y_sample_c,
	output logic                        done,
	output logic [11:0]                 raw_x_filtered,
	output logic [11:0]                 raw_y_filtered,
	output logic [15:0]                 screen_x,
	output logic [15:0]                 screen_y,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsfm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	output logic [31:0]                 prdata,
	output logic                        pready
);

	import tsfm_pkg::*;

	localparam int SZ_MAX = (SCREEN_WIDTH > SCREEN_HEIGHT) ? SCREEN_WIDTH : SCREEN_HEIGHT;
	localparam int SZW    = $clog2(SZ_MAX + 1);
	localparam int QW     = SAMPLE_W + SZW;
	localparam int NSTG   = (QW + DIV_BITS - 1) / DIV_BITS;

	// calibration registers
	logic [11:0] x_offset_q, x_span_q, y_offset_q, y_span_q;
	logic        swap_axes_q, mirror_x_q, mirror_y_q;
	logic        wr_en;
	logic [REG_IDX_W-1:0] reg_idx;

	assign pready  = 1'b1;
	assign busy    = 1'b0;
	assign wr_en   = psel & penable & pwrite;
	assign reg_idx = paddr[ADDR_W-1:2];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_offset_q  <= OFFSET_RST;
			x_span_q    <= SPAN_RST;
			y_offset_q  <= OFFSET_RST;
			y_span_q    <= SPAN_RST;
			swap_axes_q <= 1'b1;
			mirror_x_q  <= 1'b1;
			mirror_y_q  <= 1'b0;
		end else if (wr_en) begin
			unique case (reg_idx)
				REG_X_OFFSET:  x_offset_q  <= pwdata[11:0];
				REG_X_SPAN:    x_span_q    <= pwdata[11:0];
				REG_Y_OFFSET:  y_offset_q  <= pwdata[11:0];
				REG_Y_SPAN:    y_span_q    <= pwdata[11:0];
				REG_SWAP_AXES: swap_axes_q <= pwdata[0];
				REG_MIRROR_X:  mirror_x_q  <= pwdata[0];
				REG_MIRROR_Y:  mirror_y_q  <= pwdata[0];
				default: ;
			endcase
		end
	end

	always_comb begin
		prdata = '0;
		unique case (reg_idx)
			REG_X_OFFSET:  prdata = {20'd0, x_offset_q};
			REG_X_SPAN:    prdata = {20'd0, x_span_q};
			REG_Y_OFFSET:  prdata = {20'd0, y_offset_q};
			REG_Y_SPAN:    prdata = {20'd0, y_span_q};
			REG_SWAP_AXES: prdata = {31'd0, swap_axes_q};
			REG_MIRROR_X:  prdata = {31'd0, mirror_x_q};
			REG_MIRROR_Y:  prdata = {31'd0, mirror_y_q};
			default:       prdata = '0;
		endcase
	end

	// zero span acts as one
	logic [11:0] divx, divy;
	assign divx = (x_span_q == 12'd0) ? 12'd1 : x_span_q;
	assign divy = (y_span_q == 12'd0) ? 12'd1 : y_span_q;

	function automatic logic [11:0] pick_pair(input logic [11:0] s0, input logic [11:0] s1,
			input logic [11:0] s2);
		logic [11:0] d01, d02, d12, u, v;
		logic [12:0] sum;
		d01 = (s0 > s1) ? s0 - s1 : s1 - s0;
		d02 = (s0 > s2) ? s0 - s2 : s2 - s0;
		d12 = (s1 > s2) ? s1 - s2 : s2 - s1;
		u = s0;
		v = s1;
		if (d01 > d02 || d01 > d12) begin
			if (d02 > d12) u = s2;
			else v = s2;
		end
		sum = {1'b0, u} + {1'b0, v};
		return sum[12:1];
	endfunction

	// stage 1: closest-pair filter
	logic        valid_s1;
	logic [11:0] fx_s1, fy_s1;

	// stage 2: swap, offset, magnitude
	logic        valid_s2;
	logic [11:0] fx_s2, fy_s2, magx_s2, magy_s2;
	logic        negx_s2, negy_s2;
	logic [11:0] hx, hy;
	logic [12:0] dx, dy, ndx, ndy;

	assign hx  = swap_axes_q ? fy_s1 : fx_s1;
	assign hy  = swap_axes_q ? fx_s1 : fy_s1;
	assign dx  = {1'b0, hx} - {1'b0, x_offset_q};
	assign dy  = {1'b0, hy} - {1'b0, y_offset_q};
	assign ndx = -dx;
	assign ndy = -dy;

	// stage 3: scale by screen size
	logic          valid_s3;
	logic [11:0]   fx_s3, fy_s3;
	logic          negx_s3, negy_s3;
	logic [QW-1:0] prodx_s3, prody_s3;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
			valid_s2 <= 1'b0;
			valid_s3 <= 1'b0;
		end else begin
			valid_s1 <= start;
			valid_s2 <= valid_s1;
			valid_s3 <= valid_s2;
		end
	end

	always_ff @(posedge clk) begin
		fx_s1    <= pick_pair(x_sample_a, x_sample_b, x_sample_c);
		fy_s1    <= pick_pair(y_sample_a, y_sample_b, y_sample_c);
		fx_s2    <= fx_s1;
		fy_s2    <= fy_s1;
		negx_s2  <= dx[12];
		negy_s2  <= dy[12];
		magx_s2  <= dx[12] ? ndx[11:0] : dx[11:0];
		magy_s2  <= dy[12] ? ndy[11:0] : dy[11:0];
		fx_s3    <= fx_s2;
		fy_s3    <= fy_s2;
		negx_s3  <= negx_s2;
		negy_s3  <= negy_s2;
		prodx_s3 <= QW'(magx_s2) * QW'(SCREEN_WIDTH);
		prody_s3 <= QW'(magy_s2) * QW'(SCREEN_HEIGHT);
	end

	// divider stages: numerator shifts out at the top, quotient shifts in at the bottom
	logic          valid_s4 [1:NSTG];
	logic [11:0]   fx_s4    [1:NSTG];
	logic [11:0]   fy_s4    [1:NSTG];
	logic          negx_s4  [1:NSTG];
	logic          negy_s4  [1:NSTG];
	logic [QW-1:0] nqx_s4   [1:NSTG];
	logic [QW-1:0] nqy_s4   [1:NSTG];
	logic [11:0]   remx_s4  [1:NSTG];
	logic [11:0]   remy_s4  [1:NSTG];

	for (genvar k = 0; k < NSTG; k++) begin : g_div
		logic          vld_in, negx_in, negy_in;
		logic [11:0]   fx_in, fy_in, remx_in, remy_in, rx, ry;
		logic [QW-1:0] nqx_in, nqy_in, nx, ny;
		logic [12:0]   tx, ty;

		if (k == 0) begin : g_first
			assign vld_in  = valid_s3;
			assign fx_in   = fx_s3;
			assign fy_in   = fy_s3;
			assign negx_in = negx_s3;
			assign negy_in = negy_s3;
			assign nqx_in  = prodx_s3;
			assign nqy_in  = prody_s3;
			assign remx_in = '0;
			assign remy_in = '0;
		end else begin : g_next
			assign vld_in  = valid_s4[k];
			assign fx_in   = fx_s4[k];
			assign fy_in   = fy_s4[k];
			assign negx_in = negx_s4[k];
			assign negy_in = negy_s4[k];
			assign nqx_in  = nqx_s4[k];
			assign nqy_in  = nqy_s4[k];
			assign remx_in = remx_s4[k];
			assign remy_in = remy_s4[k];
		end

		always_comb begin
			nx = nqx_in;
			ny = nqy_in;
			rx = remx_in;
			ry = remy_in;
			tx = '0;
			ty = '0;
			for (int j = 0; j < DIV_BITS; j++) begin
				if (k * DIV_BITS + j < QW) begin
					tx = {rx, nx[QW-1]};
					ty = {ry, ny[QW-1]};
					nx = {nx[QW-2:0], 1'b0};
					ny = {ny[QW-2:0], 1'b0};
					if (tx >= {1'b0, divx}) begin
						tx    = tx - {1'b0, divx};
						nx[0] = 1'b1;
					end
					if (ty >= {1'b0, divy}) begin
						ty    = ty - {1'b0, divy};
						ny[0] = 1'b1;
					end
					rx = tx[11:0];
					ry = ty[11:0];
				end
			end
		end

		always_ff @(posedge clk or negedge arst_n) begin
			if (!arst_n) valid_s4[k+1] <= 1'b0;
			else valid_s4[k+1] <= vld_in;
		end

		always_ff @(posedge clk) begin
			fx_s4[k+1]   <= fx_in;
			fy_s4[k+1]   <= fy_in;
			negx_s4[k+1] <= negx_in;
			negy_s4[k+1] <= negy_in;
			nqx_s4[k+1]  <= nx;
			nqy_s4[k+1]  <= ny;
			remx_s4[k+1] <= rx;
			remy_s4[k+1] <= ry;
		end
	end

	// output stage: sign, wrap, mirror
	logic [31:0] qx_ext, qy_ext, sqx, sqy;
	logic [15:0] rx16, ry16;
	logic        done_q;
	logic [11:0] raw_x_q, raw_y_q;
	logic [15:0] screen_x_q, screen_y_q;

	assign qx_ext = 32'(nqx_s4[NSTG]);
	assign qy_ext = 32'(nqy_s4[NSTG]);
	assign sqx    = negx_s4[NSTG] ? -qx_ext : qx_ext;
	assign sqy    = negy_s4[NSTG] ? -qy_ext : qy_ext;
	assign rx16   = sqx[15:0];
	assign ry16   = sqy[15:0];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) done_q <= 1'b0;
		else done_q <= valid_s4[NSTG];
	end

	always_ff @(posedge clk) begin
		raw_x_q    <= fx_s4[NSTG];
		raw_y_q    <= fy_s4[NSTG];
		screen_x_q <= mirror_x_q ? 16'(SCREEN_WIDTH) - rx16 : rx16;
		screen_y_q <= mirror_y_q ? 16'(SCREEN_HEIGHT) - ry16 : ry16;
	end

	assign done           = done_q;
	assign raw_x_filtered = raw_x_q;
	assign raw_y_filtered = raw_y_q;
	assign screen_x       = screen_x_q;
	assign screen_y       = screen_y_q;

endmodule

`default_nettype wire

[bench/touch_map_checker.sv]
// Checker for the touch filter and mapper: predicts each request's point and compares results and register reads.
module touch_map_checker #(
	parameter int SCREEN_WIDTH  = 480,
	parameter int SCREEN_HEIGHT = 320
) (
	input  logic                        clk,
	input  logic                        arst_n,
	input  logic                        start,
	input  logic                        busy,
	input  logic [11:0]                 x_sample_a,
	input  logic [11:0]                 x_sample_b,
	input  logic [11:0]                 x_sample_c,
	input  logic [11:0]                 y_sample_a,
	input  logic [11:0]                 y_sample_b,
	input  logic [11:0]                 y_sample_c,
	input  logic                        done,
	input  logic [11:0]                 raw_x_filtered,
	input  logic [11:0]                 raw_y_filtered,
	input  logic [15:0]                 screen_x,
	input  logic [15:0]                 screen_y,
	input  logic                        psel,
	input  logic                        penable,
	input  logic                        pwrite,
	input  logic [tsfm_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                 pwdata,
	input  logic [31:0]                 prdata,
	input  logic                        pready,
	output int                          mismatches,
	output int                          outstanding,
	output int                          points_checked
);
	timeunit 1ns;
	timeprecision 1ps;

	import tsfm_pkg::*;

	typedef struct packed {
		logic [11:0] raw_x;
		logic [11:0] raw_y;
		logic [15:0] scr_x;
		logic [15:0] scr_y;
	} touch_point_t;

	touch_point_t pending_points[$];
	touch_point_t exp_pt;

	logic [11:0] x_off, x_spn, y_off, y_spn;
	logic        swap_xy, mir_x, mir_y;

	function automatic logic [11:0] closest_pair_avg(logic [11:0] s0, logic [11:0] s1,
			logic [11:0] s2);
		int a, b, c, d01, d02, d12, u, v;
		a = int'(s0);
		b = int'(s1);
		c = int'(s2);
		d01 = a > b ? a - b : b - a;
		d02 = a > c ? a - c : c - a;
		d12 = b > c ? b - c : c - b;
		u = a;
		v = b;
		if (d01 > d02 || d01 > d12) begin
			if (d02 > d12)
				u = c;
			else
				v = c;
		end
		return 12'((u + v) >> 1);
	endfunction

	function automatic logic [15:0] scale_axis(logic [11:0] val, logic [11:0] off,
			logic [11:0] spn, int size, logic mirror);
		int diff, dvs, quo;
		logic [15:0] r;
		diff = int'(val) - int'(off);
		dvs = (spn == 12'd0) ? 1 : int'(spn);
		quo = (diff * size) / dvs;
		r = quo[15:0];
		if (mirror)
			r = 16'(size - int'(r));
		return r;
	endfunction

	function automatic touch_point_t predict_point();
		touch_point_t pt;
		logic [11:0] hx, hy;
		pt.raw_x = closest_pair_avg(x_sample_a, x_sample_b, x_sample_c);
		pt.raw_y = closest_pair_avg(y_sample_a, y_sample_b, y_sample_c);
		hx = swap_xy ? pt.raw_y : pt.raw_x;
		hy = swap_xy ? pt.raw_x : pt.raw_y;
		pt.scr_x = scale_axis(hx, x_off, x_spn, SCREEN_WIDTH, mir_x);
		pt.scr_y = scale_axis(hy, y_off, y_spn, SCREEN_HEIGHT, mir_y);
		return pt;
	endfunction

	function automatic logic [31:0] reg_readback(logic [REG_IDX_W-1:0] idx);
		case (idx)
			REG_X_OFFSET:  return {20'd0, x_off};
			REG_X_SPAN:    return {20'd0, x_spn};
			REG_Y_OFFSET:  return {20'd0, y_off};
			REG_Y_SPAN:    return {20'd0, y_spn};
			REG_SWAP_AXES: return {31'd0, swap_xy};
			REG_MIRROR_X:  return {31'd0, mir_x};
			REG_MIRROR_Y:  return {31'd0, mir_y};
			default:       return '0;
		endcase
	endfunction

	task automatic compare_field(string name, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			$error("%s: expected %0d, got %0d", name, want, got);
			mismatches++;
		end
	endtask

	always @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			x_off = OFFSET_RST;
			x_spn = SPAN_RST;
			y_off = OFFSET_RST;
			y_spn = SPAN_RST;
			swap_xy = 1'b1;
			mir_x = 1'b1;
			mir_y = 1'b0;
			pending_points.delete();
			mismatches = 0;
			points_checked = 0;
		end else begin
			if (done) begin
				if (pending_points.size() == 0) begin
					$error("result with no request waiting: x=%0d y=%0d", screen_x, screen_y);
					mismatches++;
				end else begin
					exp_pt = pending_points.pop_front();
					compare_field("raw_x_filtered", 32'(exp_pt.raw_x), 32'(raw_x_filtered));
					compare_field("raw_y_filtered", 32'(exp_pt.raw_y), 32'(raw_y_filtered));
					compare_field("screen_x", 32'(exp_pt.scr_x), 32'(screen_x));
					compare_field("screen_y", 32'(exp_pt.scr_y), 32'(screen_y));
					points_checked++;
				end
			end
			if (psel && penable && pready) begin
				if (pwrite) begin
					case (paddr[ADDR_W-1:2])
						REG_X_OFFSET:  x_off = pwdata[11:0];
						REG_X_SPAN:    x_spn = pwdata[11:0];
						REG_Y_OFFSET:  y_off = pwdata[11:0];
						REG_Y_SPAN:    y_spn = pwdata[11:0];
						REG_SWAP_AXES: swap_xy = pwdata[0];
						REG_MIRROR_X:  mir_x = pwdata[0];
						REG_MIRROR_Y:  mir_y = pwdata[0];
						default: ;
					endcase
				end else if (paddr[ADDR_W-1:2] <= REG_MIRROR_Y) begin
					compare_field("prdata", reg_readback(paddr[ADDR_W-1:2]), prdata);
				end
			end
			if (start && !busy)
				pending_points.push_back(predict_point());
		end
		outstanding = pending_points.size();
	end

endmodule

[bench/tb_touch_sample_filter_and_map_core.sv]
// Testbench top for the touch filter and mapper: reset, calibration writes, register reads and touch requests.
module tb_touch_sample_filter_and_map_core;
	timeunit 1ns;
	timeprecision 1ps;

	import tsfm_pkg::*;

	localparam int SCREEN_WIDTH  = 480;
	localparam int SCREEN_HEIGHT = 320;
	localparam logic [REG_IDX_W-1:0] REG_UNUSED = 3'd7;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int DRAIN_CYCLES  = 30;
	localparam int PHASES        = 14;
	localparam int PHASE_POINTS  = 100;

	logic              clk = 1'b0;
	logic              arst_n = 1'b0;
	logic              start = 1'b0;
	logic              busy;
	logic [11:0]       x_sample_a = '0, x_sample_b = '0, x_sample_c = '0;
	logic [11:0]       y_sample_a = '0, y_sample_b = '0, y_sample_c = '0;
	logic              done;
	logic [11:0]       raw_x_filtered, raw_y_filtered;
	logic [15:0]       screen_x, screen_y;
	logic              psel = 1'b0, penable = 1'b0, pwrite = 1'b0;
	logic [ADDR_W-1:0] paddr = '0;
	logic [31:0]       pwdata = '0;
	logic [31:0]       prdata;
	logic              pready;

	int  mismatches, outstanding, points_checked;
	int  cycle_count = 0;
	int  requests = 0;
	int  settings = 0;
	bit  steady = 1'b0;

	touch_sample_filter_and_map_core #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) uut (.*);

	touch_map_checker #(
		.SCREEN_WIDTH(SCREEN_WIDTH),
		.SCREEN_HEIGHT(SCREEN_HEIGHT)
	) checker_i (.*);

	initial begin
		forever #6 clk = ~clk;
	end

	always @(posedge clk) begin
		cycle_count <= cycle_count + 1;
		if (cycle_count == CYCLE_LIMIT) begin
			$display("TB_ERROR");
			$finish;
		end
	end

	function automatic logic [11:0] clamp12(int v);
		return v < 0 ? 12'd0 : (v > 4095 ? 12'd4095 : 12'(v));
	endfunction

	function automatic logic [31:0] with_junk(logic [11:0] v);
		logic [31:0] r;
		r = $urandom;
		return $urandom_range(0, 1) ? {r[31:12], v} : {20'd0, v};
	endfunction

	task automatic idle_gap();
		int n;
		if (steady || $urandom_range(0, 99) >= 12)
			return;
		n = $urandom_range(1, 2);
		repeat (n) begin
			@(negedge clk);
			start = 1'b0;
			x_sample_a = 12'($urandom);
			x_sample_b = 12'($urandom);
			x_sample_c = 12'($urandom);
			y_sample_a = 12'($urandom);
			y_sample_b = 12'($urandom);
			y_sample_c = 12'($urandom);
		end
	endtask

	task automatic send_touch(logic [11:0] xa, logic [11:0] xb, logic [11:0] xc,
			logic [11:0] ya, logic [11:0] yb, logic [11:0] yc);
		idle_gap();
		@(negedge clk);
		x_sample_a = xa;
		x_sample_b = xb;
		x_sample_c = xc;
		y_sample_a = ya;
		y_sample_b = yb;
		y_sample_c = yc;
		start = 1'b1;
		@(posedge clk);
		while (busy)
			@(posedge clk);
		requests++;
	endtask

	task automatic settle();
		@(negedge clk);
		start = 1'b0;
		while (outstanding != 0)
			@(negedge clk);
		repeat (3) @(negedge clk);
	endtask

	task automatic apb_access(logic wr, logic [REG_IDX_W-1:0] idx, logic [31:0] data);
		@(negedge clk);
		psel = 1'b1;
		penable = 1'b0;
		pwrite = wr;
		paddr = {idx, 2'b00};
		pwdata = data;
		@(negedge clk);
		penable = 1'b1;
		@(posedge clk);
		while (!pready)
			@(posedge clk);
		@(negedge clk);
		psel = 1'b0;
		penable = 1'b0;
	endtask

	task automatic read_all_regs();
		for (int i = 0; i <= int'(REG_MIRROR_Y); i++)
			apb_access(1'b0, REG_IDX_W'(i), 32'($urandom));
	endtask

	task automatic configure(logic [11:0] xo, logic [11:0] xs, logic [11:0] yo,
			logic [11:0] ys, logic sw, logic mx, logic my);
		settle();
		apb_access(1'b1, REG_X_OFFSET, with_junk(xo));
		apb_access(1'b1, REG_X_SPAN, with_junk(xs));
		apb_access(1'b1, REG_Y_OFFSET, with_junk(yo));
		apb_access(1'b1, REG_Y_SPAN, with_junk(ys));
		apb_access(1'b1, REG_SWAP_AXES, with_junk(12'(sw)));
		apb_access(1'b1, REG_MIRROR_X, with_junk(12'(mx)));
		apb_access(1'b1, REG_MIRROR_Y, with_junk(12'(my)));
		// writes to the unmapped slot must not disturb anything
		apb_access(1'b1, REG_UNUSED, $urandom);
		read_all_regs();
		settings++;
	endtask

	// mostly three close readings around one spot, sometimes with a stray one, else random or full-scale values
	task automatic gen_axis(output logic [11:0] a, output logic [11:0] b,
			output logic [11:0] c);
		int kind, base, spread;
		kind = $urandom_range(0, 9);
		base = $urandom_range(0, 4095);
		spread = $urandom_range(0, 1) ? 8 : 64;
		if (kind == 0) begin
			a = 12'($urandom);
			b = 12'($urandom);
			c = 12'($urandom);
		end else if (kind == 1) begin
			a = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
			b = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
			c = $urandom_range(0, 1) ? 12'd4095 : 12'd0;
		end else begin
			a = clamp12(base + int'($urandom_range(0, 2 * spread)) - spread);
			b = clamp12(base + int'($urandom_range(0, 2 * spread)) - spread);
			c = clamp12(base + int'($urandom_range(0, 2 * spread)) - spread);
			if (kind >= 7) begin
				case ($urandom_range(0, 2))
					0: a = 12'($urandom);
					1: b = 12'($urandom);
					default: c = 12'($urandom);
				endcase
			end
		end
	endtask

	initial begin
		logic [11:0] xa, xb, xc, ya, yb, yc;
		repeat (5) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		// reset calibration: swapped axes, mirrored x
		send_touch(0, 0, 0, 0, 0, 0);
		send_touch(4095, 4095, 4095, 4095, 4095, 4095);
		send_touch(100, 102, 4000, 4000, 4002, 4001);
		send_touch(0, 4095, 4094, 4095, 0, 1);
		send_touch(10, 4095, 12, 4000, 0, 4003);
		send_touch(100, 110, 90, 100, 90, 110);
		send_touch(0, 100, 50, 0, 10, 20);
		send_touch(299, 299, 299, 300, 300, 300);
		send_touch(3900, 3900, 3900, 299, 298, 297);
		send_touch(12'hAAA, 12'hAAA, 12'h555, 12'h555, 12'h555, 12'hAAA);
		send_touch(1, 2, 3, 4094, 4095, 4093);
		send_touch(2048, 2047, 2049, 1, 0, 4095);
		send_touch(4095, 0, 2048, 2048, 4095, 0);
		send_touch(300, 3899, 3900, 0, 1, 4095);
		settle();
		read_all_regs();

		for (int p = 0; p < PHASES; p++) begin
			case (p)
				0: configure(0, 1, 0, 1, 1'b0, 1'b0, 1'b0);
				1: configure(4095, 4095, 4095, 4095, 1'b1, 1'b1, 1'b1);
				2: configure(0, 0, 4095, 0, 1'b0, 1'b1, 1'b1);
				3: configure(4095, 1, 0, 4095, 1'b1, 1'b0, 1'b1);
				default: configure(12'($urandom), $urandom_range(0, 3) == 0 ?
						12'($urandom_range(0, 2)) : 12'($urandom),
						12'($urandom), $urandom_range(0, 3) == 0 ?
						12'($urandom_range(0, 2)) : 12'($urandom),
						1'($urandom), 1'($urandom), 1'($urandom));
			endcase
			steady = (p == 6);
			repeat (PHASE_POINTS) begin
				gen_axis(xa, xb, xc);
				gen_axis(ya, yb, yc);
				send_touch(xa, xb, xc, ya, yb, yc);
			end
		end

		settle();
		repeat (DRAIN_CYCLES) @(negedge clk);
		$display("Ran %0d touch requests, %0d points checked, over %0d calibration settings",
			requests, points_checked, settings + 1);
		$display("Covered pair ties, zero spans, offsets above the sample and wrapped mirrors");
		if (mismatches == 0)
			$display("TB_OK");
		else
			$display("TB_ERROR");
		$finish;
	end

endmodule

[sim.f]
rtl/tsfm_pkg.sv
rtl/touch_sample_filter_and_map_core.sv
bench/touch_map_checker.sv
bench/tb_touch_sample_filter_and_map_core.sv
